### src/pcat_pkg.sv
// shared types and constants of the pci configuration address translator
package pcat_pkg;

   localparam int CSR_DATA_W = 64;
   localparam int ADDR_W     = 64;
   localparam int DESC_W     = 33;
   localparam int REL_W      = 28;

   localparam logic [31:0] LEGACY_ENABLE    = 32'h8000_0000;
   localparam logic [15:0] LEGACY_DATA_PORT = 16'h0CFC;

   localparam logic [2:0] SIZE_BYTE  = 3'd1;
   localparam logic [2:0] SIZE_WORD  = 3'd2;
   localparam logic [2:0] SIZE_DWORD = 3'd4;

   // window descriptor as laid out in the register
   typedef struct packed {
      logic        valid;
      logic [15:0] segment;
      logic [7:0]  first_bus;
      logic [7:0]  end_bus;
   } desc_type;

   // request after the window compare
   typedef struct packed {
      logic [7:0]  bus_number;
      logic [4:0]  device_slot;
      logic [2:0]  function_number;
      logic [11:0] reg_offset;
      logic        size_ok;
   } s1_type;

   // request after the window select
   typedef struct packed {
      logic              use_legacy;
      logic [1:0]        window_index;
      logic [ADDR_W-1:0] base;
      logic [REL_W-1:0]  rel;
      logic [31:0]       index_word;
      logic [15:0]       data_port;
      logic              size_ok;
   } s2_type;

   // finished result
   typedef struct packed {
      logic              use_legacy;
      logic [1:0]        window_index;
      logic [ADDR_W-1:0] memory_address;
      logic [31:0]       index_word;
      logic [15:0]       data_port;
      logic              size_ok;
   } rsp_type;

endpackage

### src/pcat_csr.sv
// window base and descriptor registers with their write decode
module pcat_csr #(
   parameter int WINDOWS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [$clog2(2*WINDOWS)-1:0]      csr_index,
   input  logic [pcat_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic [pcat_pkg::ADDR_W-1:0]       window_base [WINDOWS],
   output pcat_pkg::desc_type                window_desc [WINDOWS]
);
   import pcat_pkg::*;

   localparam int IdxW = $clog2(2*WINDOWS);

   logic [ADDR_W-1:0] base_ff [WINDOWS];
   logic [ADDR_W-1:0] base_in [WINDOWS];
   desc_type          desc_ff [WINDOWS];
   desc_type          desc_in [WINDOWS];

   for (genvar w = 0; w < WINDOWS; w++) begin : g_win
      always_comb begin
         base_in[w] = base_ff[w];
         desc_in[w] = desc_ff[w];
         if (csr_we && csr_index == IdxW'(2*w)) begin
            base_in[w] = csr_wdata;
         end
         if (csr_we && csr_index == IdxW'(2*w + 1)) begin
            desc_in[w] = desc_type'(csr_wdata[DESC_W-1:0]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            base_ff[w] <= '0;
            desc_ff[w] <= '0;
         end else begin
            base_ff[w] <= base_in[w];
            desc_ff[w] <= desc_in[w];
         end
      end

      assign window_base[w] = base_ff[w];
      assign window_desc[w] = desc_ff[w];
   end

endmodule

### src/pci_config_address_translator_unit.sv
// Translates a PCI configuration access into an ECAM memory address, or
// into the legacy 0xCF8 index word and 0xCFC data port when no window
// matches. One request is taken every cycle while the pipe is not backed
// up; a result passes through the three register stages: window compare,
// window select with offset build, and the 64-bit base add. A stalled
// result backs up the stages one by one, so empty stages still take new
// requests. The user must write windows through the csr port only while no
// request is in flight; the block does not enforce this. All windows are
// invalid after reset.
module pci_config_address_translator_unit #(
   parameter int WINDOWS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [$clog2(2*WINDOWS)-1:0]    csr_index,
   input  logic [pcat_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [15:0]                     req_segment,
   input  logic [7:0]                      req_bus_number,
   input  logic [4:0]                      req_device_slot,
   input  logic [2:0]                      req_function_number,
   input  logic [11:0]                     req_reg_offset,
   input  logic [2:0]                      req_access_size,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_use_legacy,
   output logic [1:0]                      rsp_window_index,
   output logic [pcat_pkg::ADDR_W-1:0]     rsp_memory_address,
   output logic [31:0]                     rsp_index_word,
   output logic [15:0]                     rsp_data_port,
   output logic                            rsp_size_ok
);
   import pcat_pkg::*;

   logic [ADDR_W-1:0] window_base [WINDOWS];
   desc_type          window_desc [WINDOWS];

   pcat_csr #(.WINDOWS(WINDOWS)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .window_base (window_base),
      .window_desc (window_desc)
   );

   logic               s1_valid_ff, s1_valid_in;
   s1_type             s1_ff, s1_in;
   logic [WINDOWS-1:0] s1_match_ff, s1_match_in;
   logic               s2_valid_ff, s2_valid_in;
   s2_type             s2_ff, s2_in;
   logic               s3_valid_ff, s3_valid_in;
   rsp_type            s3_ff, s3_in;
   logic               ready1, ready2, ready3;

   // a stage loads when it is empty or the next one loads
   assign ready3    = !s3_valid_ff || !rsp_stall;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign req_stall = !ready1;

   // stage 1: per-window compare
   always_comb begin
      for (int w = 0; w < WINDOWS; w++) begin
         s1_match_in[w] = window_desc[w].valid &&
                          window_desc[w].segment == req_segment &&
                          window_desc[w].first_bus <= req_bus_number &&
                          window_desc[w].end_bus >= req_bus_number;
      end
      s1_in.bus_number      = req_bus_number;
      s1_in.device_slot     = req_device_slot;
      s1_in.function_number = req_function_number;
      s1_in.reg_offset      = req_reg_offset;
      s1_in.size_ok         = req_access_size == SIZE_BYTE ||
                              req_access_size == SIZE_WORD ||
                              req_access_size == SIZE_DWORD;
      s1_valid_in           = ready1 ? req_valid : s1_valid_ff;
   end

   // stage 2: lowest matching window wins
   always_comb begin
      logic              found;
      logic [1:0]        widx;
      logic [ADDR_W-1:0] base;
      logic [7:0]        start;
      found = 1'b0;
      widx  = '0;
      base  = '0;
      start = '0;
      for (int w = WINDOWS - 1; w >= 0; w--) begin
         if (s1_match_ff[w]) begin
            found = 1'b1;
            widx  = 2'(w);
            base  = window_base[w];
            start = window_desc[w].first_bus;
         end
      end
      s2_in.use_legacy   = !found;
      s2_in.window_index = found ? widx : 2'd0;
      s2_in.base         = base;
      s2_in.rel          = {s1_ff.bus_number - start, s1_ff.device_slot,
                            s1_ff.function_number, s1_ff.reg_offset};
      s2_in.index_word   = LEGACY_ENABLE |
                           {8'd0, s1_ff.bus_number, s1_ff.device_slot,
                            s1_ff.function_number, s1_ff.reg_offset[7:2], 2'b00};
      s2_in.data_port    = LEGACY_DATA_PORT | {14'd0, s1_ff.reg_offset[1:0]};
      s2_in.size_ok      = s1_ff.size_ok;
      s2_valid_in        = ready2 ? s1_valid_ff : s2_valid_ff;
   end

   // stage 3: base add and path gating
   always_comb begin
      s3_in.use_legacy     = s2_ff.use_legacy;
      s3_in.window_index   = s2_ff.window_index;
      s3_in.memory_address = s2_ff.use_legacy ? '0 :
                             s2_ff.base + ADDR_W'(s2_ff.rel);
      s3_in.index_word     = s2_ff.use_legacy ? s2_ff.index_word : 32'd0;
      s3_in.data_port      = s2_ff.use_legacy ? s2_ff.data_port : 16'd0;
      s3_in.size_ok        = s2_ff.size_ok;
      s3_valid_in          = ready3 ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && req_valid) begin
         s1_ff       <= s1_in;
         s1_match_ff <= s1_match_in;
      end
      if (ready2 && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
      if (ready3 && s2_valid_ff) begin
         s3_ff <= s3_in;
      end
   end

   assign rsp_valid          = s3_valid_ff;
   assign rsp_use_legacy     = s3_ff.use_legacy;
   assign rsp_window_index   = s3_ff.window_index;
   assign rsp_memory_address = s3_ff.memory_address;
   assign rsp_index_word     = s3_ff.index_word;
   assign rsp_data_port      = s3_ff.data_port;
   assign rsp_size_ok        = s3_ff.size_ok;

   // a request is held off only when the whole pipe is backed up
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_stall)
      else $error("request stalled with an empty stage");

   // a blocked middle stage keeps its item
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !ready3 |=> s2_valid_ff)
      else $error("stage 2 item lost during stall");

   a_ecam_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_use_legacy |-> rsp_index_word == 32'd0 && rsp_data_port == 16'd0)
      else $error("legacy fields set on an ecam result");

   a_legacy_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_use_legacy |->
         rsp_memory_address == '0 && rsp_window_index == 2'd0 && rsp_index_word[31])
      else $error("malformed legacy result");

endmodule

### bench/xlat_bench_pkg.sv
// window model, expected translation store and register codes for the translator bench
`timescale 1ns / 1ps

package xlat_bench_pkg;
   import pcat_pkg::*;

   localparam int WINDOWS         = 4;
   localparam int REGS_PER_WINDOW = 2;
   localparam int CSR_INDEX_W     = $clog2(REGS_PER_WINDOW * WINDOWS);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_WINDOW_BASE_0,
      REG_WINDOW_DESC_0,
      REG_WINDOW_BASE_1,
      REG_WINDOW_DESC_1,
      REG_WINDOW_BASE_2,
      REG_WINDOW_DESC_2,
      REG_WINDOW_BASE_3,
      REG_WINDOW_DESC_3
   } csr_reg_e;

   typedef enum {CFG_ALL_ONES, CFG_CLEARED, CFG_RANDOM} cfg_style_e;

   typedef struct packed {
      logic [15:0] segment;
      logic [7:0]  bus_number;
      logic [4:0]  device_slot;
      logic [2:0]  function_number;
      logic [11:0] reg_offset;
      logic [2:0]  access_size;
   } access_type;

   class xlat_tracker;
      logic [ADDR_W-1:0] base [WINDOWS];
      desc_type          desc [WINDOWS];
      rsp_type           expected_xlat [$];
      int unsigned       errors;

      function new();
         int w;
         for (w = 0; w < WINDOWS; w++) begin
            base[w] = '0;
            desc[w] = '0;
         end
         errors = 0;
      endfunction

      function void note_csr(input logic [CSR_INDEX_W-1:0] idx,
                             input logic [CSR_DATA_W-1:0] data);
         int w;
         w = idx / REGS_PER_WINDOW;
         if (idx % REGS_PER_WINDOW == REG_WINDOW_DESC_0)
            desc[w] = desc_type'(data[DESC_W-1:0]);
         else
            base[w] = data;
      endfunction

      function rsp_type translate_access(input access_type a);
         rsp_type          r;
         desc_type         d;
         logic [7:0]       rel_bus;
         logic [REL_W-1:0] rel;
         bit               found;
         int               hit;
         int               w;
         r = '0;
         found = 1'b0;
         hit = 0;
         // lowest numbered matching window wins
         for (w = 0; w < WINDOWS; w++) begin
            d = desc[w];
            if (!found && d.valid && d.segment == a.segment &&
                d.first_bus <= a.bus_number && d.end_bus >= a.bus_number) begin
               found = 1'b1;
               hit = w;
            end
         end
         if (found) begin
            d = desc[hit];
            rel_bus = a.bus_number - d.first_bus;
            rel = {rel_bus, a.device_slot, a.function_number, 12'h000};
            r.window_index = hit[1:0];
            r.memory_address = base[hit] + ADDR_W'(rel) + ADDR_W'(a.reg_offset);
         end else begin
            r.use_legacy = 1'b1;
            r.index_word = LEGACY_ENABLE | {8'h00, a.bus_number, a.device_slot,
                                            a.function_number, a.reg_offset[7:2], 2'b00};
            r.data_port = LEGACY_DATA_PORT + 16'(a.reg_offset[1:0]);
         end
         r.size_ok = (a.access_size == SIZE_BYTE || a.access_size == SIZE_WORD ||
                      a.access_size == SIZE_DWORD);
         return r;
      endfunction

      function void note_access(input access_type a);
         expected_xlat.push_back(translate_access(a));
      endfunction

      function void compare_field(input string name, input logic [63:0] exp_val,
                                  input logic [63:0] act_val);
         if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_xlat(input rsp_type got);
         rsp_type want;
         if (expected_xlat.size() == 0) begin
            $error("result transfer with no request outstanding");
            errors++;
         end else begin
            want = expected_xlat.pop_front();
            compare_field("use_legacy", 64'(want.use_legacy), 64'(got.use_legacy));
            compare_field("window_index", 64'(want.window_index), 64'(got.window_index));
            compare_field("memory_address", want.memory_address, got.memory_address);
            compare_field("index_word", 64'(want.index_word), 64'(got.index_word));
            compare_field("data_port", 64'(want.data_port), 64'(got.data_port));
            compare_field("size_ok", 64'(want.size_ok), 64'(got.size_ok));
         end
      endfunction

      function int pending();
         return expected_xlat.size();
      endfunction
   endclass

endpackage

### bench/tb_top.sv
// top level bench for the pci configuration address translator
`timescale 1ns / 1ps

module tb_top;
   import pcat_pkg::*;
   import xlat_bench_pkg::*;

   localparam time CLK_PERIOD      = 12ns;
   localparam int  LATENCY         = 3;
   localparam int  PHASES          = 8;
   localparam int  ITEMS_PER_PHASE = 200;
   localparam int  HOLD_PHASE      = 3;
   localparam int  HOLD_CYCLES     = 60;
   localparam time TIMEOUT         = 6ms;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [15:0]            req_segment = '0;
   logic [7:0]             req_bus_number = '0;
   logic [4:0]             req_device_slot = '0;
   logic [2:0]             req_function_number = '0;
   logic [11:0]            req_reg_offset = '0;
   logic [2:0]             req_access_size = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_use_legacy;
   logic [1:0]             rsp_window_index;
   logic [ADDR_W-1:0]      rsp_memory_address;
   logic [31:0]            rsp_index_word;
   logic [15:0]            rsp_data_port;
   logic                   rsp_size_ok;

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit hold_req = 1'b0;

   xlat_tracker board = new();

   pci_config_address_translator_unit #(.WINDOWS(WINDOWS)) DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_segment         (req_segment),
      .req_bus_number      (req_bus_number),
      .req_device_slot     (req_device_slot),
      .req_function_number (req_function_number),
      .req_reg_offset      (req_reg_offset),
      .req_access_size     (req_access_size),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_use_legacy      (rsp_use_legacy),
      .rsp_window_index    (rsp_window_index),
      .rsp_memory_address  (rsp_memory_address),
      .rsp_index_word      (rsp_index_word),
      .rsp_data_port       (rsp_data_port),
      .rsp_size_ok         (rsp_size_ok)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin : rsp_check
      rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.use_legacy = rsp_use_legacy;
         got.window_index = rsp_window_index;
         got.memory_address = rsp_memory_address;
         got.index_word = rsp_index_word;
         got.data_port = rsp_data_port;
         got.size_ok = rsp_size_ok;
         board.check_xlat(got);
      end
   end

   initial begin : rsp_side
      int burst;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            // long hold-off so the stages fill and the input backs up
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 6);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT);
      $display("tb_top: FAIL");
      $finish;
   end

   function automatic access_type make_access(input logic [15:0] seg, input logic [7:0] bus,
                                              input logic [4:0] slot, input logic [2:0] func,
                                              input logic [11:0] off, input logic [2:0] size);
      access_type a;
      a.segment = seg;
      a.bus_number = bus;
      a.device_slot = slot;
      a.function_number = func;
      a.reg_offset = off;
      a.access_size = size;
      return a;
   endfunction

   function automatic access_type random_access();
      access_type a;
      desc_type   d;
      a = make_access(16'($urandom), 8'($urandom), 5'($urandom), 3'($urandom),
                      12'($urandom), 3'($urandom));
      // mostly aim at a programmed window so the ecam path gets real coverage
      if ($urandom_range(0, 9) < 7) begin
         d = board.desc[$urandom_range(0, WINDOWS - 1)];
         a.segment = d.segment;
         if (d.first_bus <= d.end_bus && $urandom_range(0, 4) != 0)
            a.bus_number = 8'($urandom_range(d.end_bus, d.first_bus));
      end
      return a;
   endfunction

   task automatic write_csr(input csr_reg_e idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      board.note_csr(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_access(input access_type a);
      int gap;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_segment <= a.segment;
      req_bus_number <= a.bus_number;
      req_device_slot <= a.device_slot;
      req_function_number <= a.function_number;
      req_reg_offset <= a.reg_offset;
      req_access_size <= a.access_size;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_access(a);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic program_windows(input cfg_style_e style);
      logic [CSR_DATA_W-1:0] base_word;
      logic [CSR_DATA_W-1:0] desc_word;
      desc_type              d;
      int                    w;
      for (w = 0; w < WINDOWS; w++) begin
         d.valid = ($urandom_range(0, 7) != 0);
         d.segment = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
         d.first_bus = 8'($urandom);
         d.end_bus = 8'($urandom);
         if (d.first_bus > d.end_bus && $urandom_range(0, 5) != 0)
            {d.first_bus, d.end_bus} = {d.end_bus, d.first_bus};
         base_word = {$urandom, $urandom};
         desc_word = 64'(d);
         // junk above the descriptor must be dropped
         if ($urandom_range(0, 7) == 0)
            desc_word[CSR_DATA_W-1:DESC_W] = 31'($urandom);
         case (style)
            CFG_ALL_ONES: begin
               base_word = '1;
               desc_word = '1;
            end
            CFG_CLEARED: begin
               base_word = '0;
               desc_word = '0;
            end
            default: ;
         endcase
         write_csr(csr_reg_e'(REG_WINDOW_BASE_0 + REGS_PER_WINDOW * w), base_word);
         write_csr(csr_reg_e'(REG_WINDOW_DESC_0 + REGS_PER_WINDOW * w), desc_word);
      end
   endtask

   initial begin : stimulus
      int phase;
      int n;
      cfg_style_e style;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no window valid yet, everything goes legacy; every access size
      send_access(make_access(16'h0000, 8'h00, 5'h00, 3'h0, 12'h000, SIZE_BYTE));
      send_access(make_access(16'hFFFF, 8'hFF, 5'h1F, 3'h7, 12'hFFF, 3'd7));
      send_access(make_access(16'h0000, 8'h01, 5'h02, 3'h3, 12'h103, SIZE_WORD));
      send_access(make_access(16'h1234, 8'h80, 5'h10, 3'h4, 12'h0FE, SIZE_DWORD));
      send_access(make_access(16'h0001, 8'h7F, 5'h0F, 3'h1, 12'hF01, 3'd0));
      send_access(make_access(16'h8000, 8'h40, 5'h05, 3'h2, 12'h0FF, 3'd3));
      send_access(make_access(16'h00FF, 8'h20, 5'h11, 3'h5, 12'h802, 3'd5));
      send_access(make_access(16'hFF00, 8'h10, 5'h1E, 3'h6, 12'h3FC, 3'd6));
      wait_for_results();

      // window 0 near the top of memory, window 2 with an empty bus range,
      // window 3 overlapping window 1 on the same segment
      write_csr(REG_WINDOW_BASE_0, 64'hFFFF_FFFF_FFF0_0000);
      write_csr(REG_WINDOW_DESC_0, 64'({1'b1, 16'h0000, 8'h00, 8'hFF}));
      write_csr(REG_WINDOW_BASE_1, 64'h0000_0000_E000_0000);
      write_csr(REG_WINDOW_DESC_1, 64'({1'b1, 16'h0001, 8'h10, 8'h1F}));
      write_csr(REG_WINDOW_BASE_2, 64'h0);
      write_csr(REG_WINDOW_DESC_2, 64'({1'b1, 16'h0002, 8'h20, 8'h10}));
      write_csr(REG_WINDOW_BASE_3, '1);
      write_csr(REG_WINDOW_DESC_3, 64'({1'b1, 16'h0001, 8'h00, 8'hFF}));
      send_access(make_access(16'h0000, 8'hFF, 5'h1F, 3'h7, 12'hFFF, SIZE_DWORD));
      send_access(make_access(16'h0000, 8'h00, 5'h00, 3'h0, 12'h000, SIZE_BYTE));
      send_access(make_access(16'h0001, 8'h10, 5'h03, 3'h1, 12'h040, SIZE_WORD));
      send_access(make_access(16'h0001, 8'h1F, 5'h1F, 3'h7, 12'hFFC, SIZE_DWORD));
      send_access(make_access(16'h0001, 8'h20, 5'h01, 3'h0, 12'h004, SIZE_DWORD));
      send_access(make_access(16'h0001, 8'h0F, 5'h08, 3'h2, 12'h010, SIZE_BYTE));
      send_access(make_access(16'h0002, 8'h18, 5'h04, 3'h3, 12'h123, SIZE_WORD));
      send_access(make_access(16'h0002, 8'h10, 5'h00, 3'h0, 12'h000, SIZE_BYTE));
      send_access(make_access(16'h0003, 8'h00, 5'h07, 3'h1, 12'h0A2, SIZE_DWORD));
      send_access(make_access(16'h0001, 8'hFF, 5'h1F, 3'h7, 12'hFFF, SIZE_BYTE));
      send_access(make_access(16'h0000, 8'h33, 5'h0A, 3'h5, 12'h200, 3'd7));

      for (phase = 0; phase < PHASES; phase++) begin
         req_idle_on = (phase < PHASES - 2);
         rsp_idle_on = (phase < PHASES - 2);
         wait_for_results();
         if (phase == 0)
            style = CFG_ALL_ONES;
         else if (phase == 1)
            style = CFG_CLEARED;
         else
            style = CFG_RANDOM;
         program_windows(style);
         if (phase == HOLD_PHASE)
            hold_req = 1'b1;
         for (n = 0; n < ITEMS_PER_PHASE; n++)
            send_access(random_access());
      end

      wait_for_results();
      if (board.errors == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

### sim.f
src/pcat_pkg.sv
src/pcat_csr.sv
src/pci_config_address_translator_unit.sv
bench/xlat_bench_pkg.sv
bench/tb_top.sv
